@@ rtl/kbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Kepler bisection solver package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package kbs_pkg;

	localparam int CORDIC_STEPS_DEF = 28;
	localparam int CNT_W = 5;
	localparam int CV_W = 42;
	localparam int CZ_W = 34;
	localparam int RES_W = 36;
	localparam int PROD_W = 65;

	localparam logic signed [CZ_W-1:0] Q_PI = 34'sd843314857;
	localparam logic signed [CZ_W-1:0] Q_TWO_PI = 34'sd1686629713;
	localparam logic signed [CZ_W-1:0] Q_HALF_PI = 34'sd421657428;
	localparam logic signed [CV_W-1:0] Q_CORDIC_K = 42'sd163008219;

	localparam logic [1:0] REG_ECC = 2'd0;
	localparam logic [1:0] REG_TOL = 2'd1;
	localparam logic [1:0] REG_MAXIT = 2'd2;
	localparam logic [1:0] REG_GAIN = 2'd3;

	localparam logic [31:0] ECC_RST = 32'd3554792816;
	localparam logic [28:0] TOL_RST = 29'd26844;
	localparam logic [7:0] MAXIT_RST = 8'd64;
	localparam logic [31:0] GAIN_RST = 32'd54636180;

	localparam logic [1:0] SEL_LO = 2'd0;
	localparam logic [1:0] SEL_MID = 2'd1;
	localparam logic [1:0] SEL_HALF = 2'd2;
	localparam logic [1:0] SEL_VEC = 2'd3;

	typedef struct packed {
		logic signed [31:0] mean_anomaly;
		logic signed [31:0] bracket_low;
		logic signed [31:0] bracket_high;
	} in_t;

	typedef struct packed {
		logic signed [31:0] eccentric_anomaly;
		logic signed [31:0] true_anomaly;
		logic converged;
		logic [7:0] steps_used;
	} out_t;

	typedef struct packed {
		logic load;
		logic calc_mid;
		logic cord_start;
		logic [1:0] cord_sel;
		logic mul_en;
		logic mul_gain;
		logic res_en;
		logic res_lo;
		logic set_conv;
		logic update;
		logic out_en;
	} cmd_t;

	typedef struct packed {
		logic cord_done;
		logic cord_busy;
		logic conv;
		logic cap;
		logic opposite;
	} stat_t;

	function automatic logic signed [CZ_W-1:0] atan_at(input logic [CNT_W-1:0] i);
		logic signed [CZ_W-1:0] v;
		case (i)
			5'd0: v = 34'sd210828714;
			5'd1: v = 34'sd124459457;
			5'd2: v = 34'sd65760959;
			5'd3: v = 34'sd33381290;
			5'd4: v = 34'sd16755422;
			5'd5: v = 34'sd8385879;
			5'd6: v = 34'sd4193963;
			5'd7: v = 34'sd2097109;
			5'd8: v = 34'sd1048571;
			5'd9: v = 34'sd524287;
			5'd10: v = 34'sd262144;
			5'd11: v = 34'sd131072;
			5'd12: v = 34'sd65536;
			5'd13: v = 34'sd32768;
			5'd14: v = 34'sd16384;
			5'd15: v = 34'sd8192;
			5'd16: v = 34'sd4096;
			5'd17: v = 34'sd2048;
			5'd18: v = 34'sd1024;
			5'd19: v = 34'sd512;
			5'd20: v = 34'sd256;
			5'd21: v = 34'sd128;
			5'd22: v = 34'sd64;
			5'd23: v = 34'sd32;
			5'd24: v = 34'sd16;
			5'd25: v = 34'sd8;
			5'd26: v = 34'sd4;
			5'd27: v = 34'sd2;
			5'd28: v = 34'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/kbs_cordic.sv @@
// ----------------------------------------------------------------------------
// Kepler bisection solver CORDIC unit
// Iterative CORDIC, one micro-rotation per cycle, in rotation mode (sine and
// cosine with quadrant reduction) or vectoring mode (four-quadrant atan2).
// ----------------------------------------------------------------------------
module kbs_cordic #(
	parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic vec,
	input  logic signed [31:0] ang,
	input  logic signed [kbs_pkg::CV_W-1:0] xin,
	input  logic signed [kbs_pkg::CV_W-1:0] yin,
	output logic signed [kbs_pkg::CV_W-1:0] x,
	output logic signed [kbs_pkg::CV_W-1:0] y,
	output logic signed [kbs_pkg::CZ_W-1:0] z,
	output logic flip,
	output logic busy,
	output logic done
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WRAP = 2'd1;
	localparam logic [1:0] PH_REFL = 2'd2;
	localparam logic [1:0] PH_RUN = 2'd3;
	localparam logic [kbs_pkg::CNT_W-1:0] LAST = kbs_pkg::CNT_W'(CORDIC_STEPS - 1);

	logic [1:0] phase_q;
	logic [kbs_pkg::CNT_W-1:0] cnt_q;
	logic vec_q;
	logic done_q;
	logic flip_q;
	logic signed [kbs_pkg::CV_W-1:0] x_q;
	logic signed [kbs_pkg::CV_W-1:0] y_q;
	logic signed [kbs_pkg::CZ_W-1:0] z_q;
	logic signed [kbs_pkg::CV_W-1:0] dx;
	logic signed [kbs_pkg::CV_W-1:0] dy;
	logic sigma;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign sigma = vec_q ? y_q[kbs_pkg::CV_W-1] : !z_q[kbs_pkg::CZ_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			vec_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						vec_q <= vec;
						cnt_q <= '0;
						phase_q <= vec ? PH_RUN : PH_WRAP;
					end
				end
				PH_WRAP: phase_q <= PH_REFL;
				PH_REFL: phase_q <= PH_RUN;
				PH_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						done_q <= 1'b1;
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					if (vec) begin
						if (xin < 0) begin
							x_q <= -xin;
							y_q <= -yin;
							z_q <= (yin >= 0) ? kbs_pkg::Q_PI : -kbs_pkg::Q_PI;
						end else begin
							x_q <= xin;
							y_q <= yin;
							z_q <= '0;
						end
					end else begin
						x_q <= kbs_pkg::Q_CORDIC_K;
						y_q <= '0;
						z_q <= kbs_pkg::CZ_W'(ang);
					end
				end
			end
			PH_WRAP: begin
				if (z_q > kbs_pkg::Q_PI) begin
					z_q <= z_q - kbs_pkg::Q_TWO_PI;
				end else if (z_q < -kbs_pkg::Q_PI) begin
					z_q <= z_q + kbs_pkg::Q_TWO_PI;
				end
			end
			PH_REFL: begin
				if (z_q > kbs_pkg::Q_HALF_PI) begin
					z_q <= kbs_pkg::Q_PI - z_q;
					flip_q <= 1'b1;
				end else if (z_q < -kbs_pkg::Q_HALF_PI) begin
					z_q <= -kbs_pkg::Q_PI - z_q;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
			end
			PH_RUN: begin
				if (sigma) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - kbs_pkg::atan_at(cnt_q);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + kbs_pkg::atan_at(cnt_q);
				end
			end
			default: ;
		endcase
	end

	assign x = x_q;
	assign y = y_q;
	assign z = z_q;
	assign flip = flip_q;
	assign busy = (phase_q != PH_IDLE);
	assign done = done_q;

endmodule

@@ rtl/kbs_datapath.sv @@
// ----------------------------------------------------------------------------
// Kepler bisection solver datapath
// Bracket registers, residual multiplier, convergence tests and result
// formatting around the shared CORDIC unit.
// ----------------------------------------------------------------------------
module kbs_datapath #(
	parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  kbs_pkg::cmd_t cmd,
	output kbs_pkg::stat_t stat,
	input  kbs_pkg::in_t operands,
	input  logic [31:0] ecc,
	input  logic [28:0] tol,
	input  logic [7:0] max_it,
	input  logic [31:0] gain,
	output kbs_pkg::out_t result
);

	logic signed [31:0] m_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic signed [31:0] mid_q;
	logic [32:0] w_q;
	logic signed [kbs_pkg::RES_W-1:0] rl_q;
	logic signed [kbs_pkg::RES_W-1:0] rm_q;
	logic signed [kbs_pkg::PROD_W-1:0] prod_q;
	logic [7:0] steps_q;
	logic conv_q;
	kbs_pkg::out_t result_q;

	logic signed [32:0] sum;
	logic signed [32:0] diff;
	logic signed [31:0] ang;
	logic signed [kbs_pkg::CV_W-1:0] cx;
	logic signed [kbs_pkg::CV_W-1:0] cy;
	logic signed [kbs_pkg::CZ_W-1:0] cz;
	logic cflip;
	logic signed [kbs_pkg::CV_W-1:0] cosv;
	logic signed [kbs_pkg::CV_W-1:0] yv;
	logic signed [31:0] rx;
	logic signed [kbs_pkg::RES_W-1:0] res;
	logic [kbs_pkg::RES_W-1:0] rm_abs;
	logic signed [kbs_pkg::CZ_W:0] ta2;
	logic signed [31:0] ta;

	assign sum = 33'(lo_q) + 33'(hi_q);
	assign diff = 33'(hi_q) - 33'(lo_q);

	always_comb begin
		case (cmd.cord_sel)
			kbs_pkg::SEL_LO: ang = lo_q;
			kbs_pkg::SEL_MID: ang = mid_q;
			kbs_pkg::SEL_HALF: ang = mid_q >>> 1;
			default: ang = mid_q;
		endcase
	end

	assign cosv = cflip ? -cx : cx;
	assign yv = kbs_pkg::CV_W'($signed(prod_q[kbs_pkg::PROD_W-1:24]));

	kbs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.cord_start),
		.vec(cmd.cord_sel == kbs_pkg::SEL_VEC),
		.ang(ang),
		.xin(cosv),
		.yin(yv),
		.x(cx),
		.y(cy),
		.z(cz),
		.flip(cflip),
		.busy(stat.cord_busy),
		.done(stat.cord_done)
	);

	assign rx = cmd.res_lo ? lo_q : mid_q;
	assign res = kbs_pkg::RES_W'(rx)
		- kbs_pkg::RES_W'($signed(prod_q[kbs_pkg::PROD_W-1:32]))
		- kbs_pkg::RES_W'(m_q);
	assign rm_abs = rm_q[kbs_pkg::RES_W-1] ? kbs_pkg::RES_W'(-rm_q) : kbs_pkg::RES_W'(rm_q);

	assign stat.conv = ({1'b0, w_q} < {4'b0, tol, 1'b0}) && (rm_abs < kbs_pkg::RES_W'(tol));
	assign stat.cap = (steps_q >= max_it);
	assign stat.opposite = (rl_q < 0 && rm_q > 0) || (rl_q > 0 && rm_q < 0);

	assign ta2 = {cz, 1'b0};
	always_comb begin
		if (ta2 > 35'sd2147483647) begin
			ta = 32'sh7FFFFFFF;
		end else if (ta2 < -35'sd2147483648) begin
			ta = 32'sh80000000;
		end else begin
			ta = ta2[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			conv_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				steps_q <= '0;
				conv_q <= 1'b0;
			end else if (cmd.update) begin
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.set_conv) begin
				conv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q <= operands.mean_anomaly;
			lo_q <= operands.bracket_low;
			hi_q <= operands.bracket_high;
		end
		if (cmd.calc_mid) begin
			mid_q <= sum[32:1];
			w_q <= diff[32] ? 33'(-diff) : 33'(diff);
		end
		if (cmd.mul_en) begin
			prod_q <= 65'($signed(cy[31:0])) * $signed({33'b0, cmd.mul_gain ? gain : ecc});
		end
		if (cmd.res_en) begin
			if (cmd.res_lo) begin
				rl_q <= res;
			end else begin
				rm_q <= res;
			end
		end
		if (cmd.update) begin
			if (stat.opposite) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q;
				rl_q <= rm_q;
			end
		end
		if (cmd.out_en) begin
			result_q.eccentric_anomaly <= mid_q;
			result_q.true_anomaly <= ta;
			result_q.converged <= conv_q;
			result_q.steps_used <= steps_q;
		end
	end

	assign result = result_q;

endmodule

@@ rtl/kbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Kepler bisection solver controller
// Sequences residual evaluations, bisection steps and the final true anomaly.
// ----------------------------------------------------------------------------
module kbs_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output kbs_pkg::cmd_t cmd,
	input  kbs_pkg::stat_t stat
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_LO_C = 5'd1;
	localparam logic [4:0] ST_LO_W = 5'd2;
	localparam logic [4:0] ST_LO_M = 5'd3;
	localparam logic [4:0] ST_LO_R = 5'd4;
	localparam logic [4:0] ST_MID = 5'd5;
	localparam logic [4:0] ST_MID_C = 5'd6;
	localparam logic [4:0] ST_MID_W = 5'd7;
	localparam logic [4:0] ST_MID_M = 5'd8;
	localparam logic [4:0] ST_MID_R = 5'd9;
	localparam logic [4:0] ST_TEST = 5'd10;
	localparam logic [4:0] ST_HALF_C = 5'd11;
	localparam logic [4:0] ST_HALF_W = 5'd12;
	localparam logic [4:0] ST_HALF_M = 5'd13;
	localparam logic [4:0] ST_VEC_C = 5'd14;
	localparam logic [4:0] ST_VEC_W = 5'd15;
	localparam logic [4:0] ST_OUT = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic done_q;

	always_comb begin
		cmd = '0;
		cmd.cord_sel = kbs_pkg::SEL_MID;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_LO_C;
				end
			end
			ST_LO_C: begin
				cmd.cord_start = 1'b1;
				cmd.cord_sel = kbs_pkg::SEL_LO;
				state_d = ST_LO_W;
			end
			ST_LO_W: if (stat.cord_done) state_d = ST_LO_M;
			ST_LO_M: begin
				cmd.mul_en = 1'b1;
				state_d = ST_LO_R;
			end
			ST_LO_R: begin
				cmd.res_en = 1'b1;
				cmd.res_lo = 1'b1;
				state_d = ST_MID;
			end
			ST_MID: begin
				cmd.calc_mid = 1'b1;
				state_d = ST_MID_C;
			end
			ST_MID_C: begin
				cmd.cord_start = 1'b1;
				state_d = ST_MID_W;
			end
			ST_MID_W: if (stat.cord_done) state_d = ST_MID_M;
			ST_MID_M: begin
				cmd.mul_en = 1'b1;
				state_d = ST_MID_R;
			end
			ST_MID_R: begin
				cmd.res_en = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (stat.conv) begin
					cmd.set_conv = 1'b1;
					state_d = ST_HALF_C;
				end else if (stat.cap) begin
					state_d = ST_HALF_C;
				end else begin
					cmd.update = 1'b1;
					state_d = ST_MID;
				end
			end
			ST_HALF_C: begin
				cmd.cord_start = 1'b1;
				cmd.cord_sel = kbs_pkg::SEL_HALF;
				state_d = ST_HALF_W;
			end
			ST_HALF_W: if (stat.cord_done) state_d = ST_HALF_M;
			ST_HALF_M: begin
				cmd.mul_en = 1'b1;
				cmd.mul_gain = 1'b1;
				state_d = ST_VEC_C;
			end
			ST_VEC_C: begin
				cmd.cord_start = 1'b1;
				cmd.cord_sel = kbs_pkg::SEL_VEC;
				state_d = ST_VEC_W;
			end
			ST_VEC_W: if (stat.cord_done) state_d = ST_OUT;
			ST_OUT: begin
				cmd.out_en = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.out_en;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_start_idle_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cord_start |-> !stat.cord_busy)
		else $error("CORDIC started while still running");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not make the block busy");
	a_done_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_OUT)
		else $error("result strobe without output state");

endmodule

@@ rtl/kepler_bisection_solver.sv @@
// ----------------------------------------------------------------------------
// Kepler bisection solver
// Solves E - e*sin(E) = M by bisection and gives E and the true anomaly.
// ----------------------------------------------------------------------------
// One transaction is taken while busy is low and start is high. The time from
// the accepting edge to the result strobe grows with the number of bisection
// steps, up to the max_it cap of 255 steps. The time is set by the single
// shared iterative CORDIC unit that evaluates every sine and the final atan2.
// The result appears for exactly one cycle with done high and cannot be
// stalled; the receiver must take it then.
// Configuration writes land at once.
module kepler_bisection_solver #(
	parameter int CORDIC_STEPS = kbs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  kbs_pkg::in_t operands,
	output logic done,
	output kbs_pkg::out_t result,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] ecc_q;
	logic [28:0] tol_q;
	logic [7:0] maxit_q;
	logic [31:0] gain_q;
	kbs_pkg::cmd_t cmd;
	kbs_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q <= kbs_pkg::ECC_RST;
			tol_q <= kbs_pkg::TOL_RST;
			maxit_q <= kbs_pkg::MAXIT_RST;
			gain_q <= kbs_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kbs_pkg::REG_ECC: ecc_q <= cfg_data;
				kbs_pkg::REG_TOL: tol_q <= cfg_data[28:0];
				kbs_pkg::REG_MAXIT: maxit_q <= cfg_data[7:0];
				kbs_pkg::REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	kbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cmd(cmd),
		.stat(stat)
	);

	kbs_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.operands(operands),
		.ecc(ecc_q),
		.tol(tol_q),
		.max_it(maxit_q),
		.gain(gain_q),
		.result(result)
	);

endmodule
